### design/zpb_pkg.sv
// shared types, constants and coefficient tables for the zero-phase bandpass block
// no dependencies; used by zpb_mac, zpb_div, the top level and the testbench
`timescale 1ns / 1ps
package zpb_pkg;

    localparam int TAPS     = 7;
    localparam int SAMPLE_W = 24;
    localparam int SIG_W    = 40;
    localparam int COEF_W   = 24;
    localparam int PROD_W   = SIG_W + COEF_W;
    localparam int RND_SH   = 20;
    localparam int RND_W    = PROD_W - RND_SH;
    localparam int ACC_W    = 47;
    localparam int VAL_W    = 24;
    localparam int FRAC_B   = 22;
    localparam int Q_W      = FRAC_B + 1;
    localparam int DIV_W    = SIG_W + FRAC_B + 1;
    localparam int JW       = $clog2(TAPS) + 1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SIG_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (SIG_W - 1));

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FEW  = 2'd1,
        STAT_DROP = 2'd2,
        STAT_ZERO = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P_D0,
        S_P_D1,
        S_P_D2,
        S_P_RD,
        S_P_WR,
        S_Z_RD,
        S_Z_X,
        S_Z_M,
        S_F_RD,
        S_F_X,
        S_F_Y,
        S_F_B,
        S_F_A,
        S_CHECK,
        S_O_RD,
        S_O_Y,
        S_O_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample_in;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] filtered_value;
        logic                    last_sample;
        logic [1:0]              status;
    } rsp_t;

    typedef struct packed {
        logic             start;
        logic [SIG_W-1:0] mag;
        logic [SIG_W-1:0] peak;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } div_rsp_t;

    localparam logic signed [COEF_W-1:0] B_TAB [0:1][0:TAPS-1] = '{
        '{24'sd248394, 24'sd0, -24'sd745181, 24'sd0, 24'sd745181, 24'sd0, -24'sd248394},
        '{24'sd47834, 24'sd0, -24'sd143501, 24'sd0, 24'sd143501, 24'sd0, -24'sd47834}
    };
    localparam logic signed [COEF_W-1:0] A_TAB [0:1][0:TAPS-1] = '{
        '{24'sd1048576, -24'sd2441159, 24'sd1691707, -24'sd577515, 24'sd573139,
          -24'sd248195, -24'sd46025},
        '{24'sd1048576, -24'sd4355797, 24'sd7552855, -24'sd7137956, 24'sd3954152,
          -24'sd1217488, 24'sd155670}
    };
    localparam logic signed [COEF_W-1:0] ZI_TAB [0:1][0:TAPS-2] = '{
        '{-24'sd248394, -24'sd248394, 24'sd496788, 24'sd496788, -24'sd248394, -24'sd248394},
        '{-24'sd47834, -24'sd47834, 24'sd95667, 24'sd95667, -24'sd47834, -24'sd47834}
    };

    function automatic logic signed [COEF_W-1:0] coef_b(input logic rate,
                                                        input logic [JW-1:0] idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx < JW'(TAPS))
            c = B_TAB[rate][idx[JW-2:0]];
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_a(input logic rate,
                                                        input logic [JW-1:0] idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx < JW'(TAPS))
            c = A_TAB[rate][idx[JW-2:0]];
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_zi(input logic rate,
                                                         input logic [JW-1:0] idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx < JW'(TAPS - 1))
            c = ZI_TAB[rate][idx[JW-2:0]];
        return c;
    endfunction

    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v;
        if (v > SAT_HI)
            t = SAT_HI;
        else if (v < SAT_LO)
            t = SAT_LO;
        return t[SIG_W-1:0];
    endfunction

endpackage

### design/zpb_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module zpb_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1060
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### design/zpb_mac.sv
// shared multiplier: signal times coefficient, registered product, rounded to Q8
// depends on zpb_pkg
`timescale 1ns / 1ps
module zpb_mac (
    input  logic                                clk,
    input  logic signed [zpb_pkg::SIG_W-1:0]    op_s,
    input  logic signed [zpb_pkg::COEF_W-1:0]   op_c,
    output logic signed [zpb_pkg::RND_W-1:0]    rnd
);

    localparam int PW = zpb_pkg::PROD_W;

    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] p_next;
    logic [PW-1:0]        mag;
    logic [PW-1:0]        rsum;
    logic [zpb_pkg::RND_W-1:0] r;

    assign p_next = op_s * op_c;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    // round half away from zero on the magnitude
    assign mag  = p_reg[PW-1] ? PW'(-p_reg) : PW'(p_reg);
    assign rsum = mag + (PW'(1) << (zpb_pkg::RND_SH - 1));
    assign r    = rsum[PW-1:zpb_pkg::RND_SH];
    assign rnd  = p_reg[PW-1] ? -$signed(r) : $signed(r);

endmodule

### design/zpb_div.sv
// restoring divider, one quotient bit a cycle: round(mag * 2^22 / peak)
// depends on zpb_pkg
`timescale 1ns / 1ps
module zpb_div (
    input  logic              clk,
    input  logic              rst_n,
    input  zpb_pkg::div_req_t req,
    output zpb_pkg::div_rsp_t rsp
);

    localparam int DW = zpb_pkg::DIV_W;
    localparam int CNT_W = $clog2(zpb_pkg::Q_W + 1);

    logic [DW-1:0]           rem_reg;
    logic [DW-1:0]           ds_reg;
    logic [zpb_pkg::Q_W-1:0] q_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic                    ge;

    assign ge = (rem_reg >= ds_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(zpb_pkg::Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            // numerator carries the half-divisor for rounding
            rem_reg <= (DW'(req.mag) << zpb_pkg::FRAC_B) + DW'(req.peak >> 1);
            ds_reg  <= DW'(req.peak) << zpb_pkg::FRAC_B;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - ds_reg;
            q_reg  <= {q_reg[zpb_pkg::Q_W-2:0], ge};
            ds_reg <= ds_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

### design/zero_phase_iir_bandpass_top.sv
// top level of the zero-phase bandpass: sequencer, sample and work buffers
// depends on zpb_pkg, zpb_ram, zpb_mac, zpb_div
//
//  channel  signals                         word
//  req      req_valid / req_stall / req     zpb_pkg::req_t (kind, sample_in)
//  rsp      rsp_valid / rsp_stall / rsp     zpb_pkg::rsp_t (value, last, status)
//  cfg      cfg_valid / cfg_ready / cfg_data  rate_select bit
//
// a load is taken in the idle state and leaves the sequencer idle; a read of a filtered
// block waits on the bit-serial divider (23 steps); the first read of a block also pads
// it to L = n + 2*PAD_LENGTH samples and filters it forward and backward on the one
// shared multiplier. req_stall is high while the sequencer is busy.
// reset is asynchronous active low; the sample buffers need no clearing pass.
// a result waits in the output register while rsp_stall is high.
`timescale 1ns / 1ps
module zero_phase_iir_bandpass_top #(
    parameter int MAX_SAMPLES = 1024,
    parameter int PAD_LENGTH  = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  zpb_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output zpb_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    localparam int BUF_LEN = MAX_SAMPLES + 2 * PAD_LENGTH;
    localparam int IAW = $clog2(MAX_SAMPLES);
    localparam int BAW = $clog2(BUF_LEN);
    localparam int CW  = $clog2(BUF_LEN + 1) + 1;
    localparam int SW  = zpb_pkg::SIG_W;
    localparam int AW  = zpb_pkg::ACC_W;
    localparam int XW  = zpb_pkg::SAMPLE_W;
    localparam int JW  = zpb_pkg::JW;
    localparam int NZ  = zpb_pkg::TAPS - 1;

    zpb_pkg::state_t state_reg, state_next;
    logic            rate_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ridx_reg, ridx_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [SW-1:0]   peak_reg, peak_next;
    logic            ready_reg, ready_next;
    logic            ovf_reg, ovf_next;
    logic            pass_reg, pass_next;
    logic [JW-1:0]   j_reg, j_next;
    logic            rsp_valid_reg, rsp_valid_next;

    logic signed [SW-1:0] x_reg, x_next;
    logic signed [SW-1:0] y_reg, y_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [SW-1:0] z_reg [NZ];
    logic signed [SW-1:0] z_next [NZ];
    logic signed [XW:0]   d0_reg, d0_next;
    logic signed [XW:0]   d1_reg, d1_next;
    logic                 sign_reg, sign_next;
    zpb_pkg::rsp_t        res_reg, res_next;
    zpb_pkg::rsp_t        rsp_reg, rsp_next;

    logic                 iwe;
    logic [IAW-1:0]       iwaddr;
    logic [IAW-1:0]       iraddr;
    logic signed [XW-1:0] irdata;
    logic                 bwe;
    logic [BAW-1:0]       bwaddr;
    logic [SW-1:0]        bwdata;
    logic [BAW-1:0]       braddr;
    logic signed [SW-1:0] brdata;

    logic signed [SW-1:0]             mac_s;
    logic signed [zpb_pkg::COEF_W-1:0] mac_c;
    logic signed [zpb_pkg::RND_W-1:0] rnd;
    zpb_pkg::div_req_t                div_req;
    zpb_pkg::div_rsp_t                div_rsp;

    logic [CW-1:0]        len_w;
    logic [CW-1:0]        eff_cnt;
    logic [CW-1:0]        src_idx;
    logic [CW-1:0]        k_idx;
    logic                 pad_left;
    logic                 pad_right;
    logic signed [XW+1:0] pad_dif;
    logic signed [AW-1:0] rnd_ext;
    logic signed [AW-1:0] z0_ext;
    logic signed [SW-1:0] y_sat;
    logic signed [SW-1:0] z_new;
    logic signed [SW-1:0] zi_sat;
    logic [SW-1:0]        y_mag;
    logic [SW-1:0]        rd_mag;
    logic                 k_inner;
    logic signed [zpb_pkg::VAL_W-1:0] q_val;

    zpb_ram #(.WIDTH(XW), .DEPTH(MAX_SAMPLES)) u_in_ram (
        .clk   (clk),
        .we    (iwe),
        .waddr (iwaddr),
        .wdata (req.sample_in),
        .raddr (iraddr),
        .rdata (irdata)
    );

    zpb_ram #(.WIDTH(SW), .DEPTH(BUF_LEN)) u_buf_ram (
        .clk   (clk),
        .we    (bwe),
        .waddr (bwaddr),
        .wdata (bwdata),
        .raddr (braddr),
        .rdata (brdata)
    );

    zpb_mac u_mac (
        .clk  (clk),
        .op_s (mac_s),
        .op_c (mac_c),
        .rnd  (rnd)
    );

    zpb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign len_w   = count_reg + CW'(2 * PAD_LENGTH);
    assign eff_cnt = ready_reg ? '0 : count_reg;
    assign pad_left  = (n_reg < CW'(PAD_LENGTH));
    assign pad_right = (n_reg >= CW'(PAD_LENGTH) + count_reg);
    // odd reflection sources: left mirrors around x[0], right around x[n-1]
    assign src_idx = pad_left  ? CW'(PAD_LENGTH) - n_reg :
                     pad_right ? (count_reg << 1) + CW'(PAD_LENGTH) - CW'(2) - n_reg :
                                 n_reg - CW'(PAD_LENGTH);
    assign pad_dif = pad_left  ? (XW+2)'(d0_reg) - (XW+2)'(irdata) :
                     pad_right ? (XW+2)'(d1_reg) - (XW+2)'(irdata) :
                                 (XW+2)'(irdata);
    assign k_idx   = pass_reg ? len_w - CW'(1) - n_reg : n_reg;
    assign k_inner = (k_idx >= CW'(PAD_LENGTH)) && (k_idx < CW'(PAD_LENGTH) + count_reg);

    assign rnd_ext = AW'(rnd);
    assign z0_ext  = AW'(z_reg[0]);
    assign y_sat   = zpb_pkg::sat_sig(z0_ext + rnd_ext);
    assign z_new   = zpb_pkg::sat_sig(acc_reg - rnd_ext);
    assign zi_sat  = zpb_pkg::sat_sig(rnd_ext);
    assign y_mag   = y_reg[SW-1] ? SW'(-y_reg) : SW'(y_reg);
    assign rd_mag  = brdata[SW-1] ? SW'(-brdata) : SW'(brdata);
    assign q_val   = sign_reg ? -$signed(zpb_pkg::VAL_W'(div_rsp.quot))
                              : $signed(zpb_pkg::VAL_W'(div_rsp.quot));

    assign req_stall = (state_reg != zpb_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= zpb_pkg::S_IDLE;
            rate_reg      <= 1'b0;
            count_reg     <= '0;
            ridx_reg      <= '0;
            n_reg         <= '0;
            peak_reg      <= '0;
            ready_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            pass_reg      <= 1'b0;
            j_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ridx_reg      <= ridx_next;
            n_reg         <= n_next;
            peak_reg      <= peak_next;
            ready_reg     <= ready_next;
            ovf_reg       <= ovf_next;
            pass_reg      <= pass_next;
            j_reg         <= j_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
                rate_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        z_reg    <= z_next;
        d0_reg   <= d0_next;
        d1_reg   <= d1_next;
        sign_reg <= sign_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ridx_next      = ridx_reg;
        n_next         = n_reg;
        peak_next      = peak_reg;
        ready_next     = ready_reg;
        ovf_next       = ovf_reg;
        pass_next      = pass_reg;
        j_next         = j_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        z_next         = z_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        sign_next      = sign_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        iwe            = 1'b0;
        iwaddr         = eff_cnt[IAW-1:0];
        iraddr         = '0;
        bwe            = 1'b0;
        bwaddr         = n_reg[BAW-1:0];
        bwdata         = SW'(pad_dif) <<< 8;
        braddr         = k_idx[BAW-1:0];
        mac_s          = x_reg;
        mac_c          = '0;
        div_req.start  = 1'b0;
        div_req.mag    = rd_mag;
        div_req.peak   = peak_reg;

        case (state_reg)
            zpb_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.kind == zpb_pkg::KIND_LOAD)
                    begin
                        // a load after a filtered block starts a new block
                        ready_next = 1'b0;
                        ridx_next  = '0;
                        if (eff_cnt < CW'(MAX_SAMPLES))
                        begin
                            iwe        = 1'b1;
                            count_next = eff_cnt + CW'(1);
                            ovf_next   = ready_reg ? 1'b0 : ovf_reg;
                        end
                        else
                        begin
                            count_next = eff_cnt;
                            ovf_next   = 1'b1;
                        end
                    end
                    else if (ready_reg)
                    begin
                        state_next = zpb_pkg::S_O_RD;
                    end
                    else if (count_reg < CW'(PAD_LENGTH + 1))
                    begin
                        res_next   = '{filtered_value: '0, last_sample: 1'b1,
                                       status: zpb_pkg::STAT_FEW};
                        state_next = zpb_pkg::S_EMIT;
                    end
                    else if (ovf_reg)
                    begin
                        res_next   = '{filtered_value: '0, last_sample: 1'b1,
                                       status: zpb_pkg::STAT_DROP};
                        state_next = zpb_pkg::S_EMIT;
                    end
                    else
                    begin
                        peak_next  = '0;
                        state_next = zpb_pkg::S_P_D0;
                    end
                end
            end
            zpb_pkg::S_P_D0:
            begin
                iraddr     = '0;
                state_next = zpb_pkg::S_P_D1;
            end
            zpb_pkg::S_P_D1:
            begin
                iraddr     = IAW'(count_reg - CW'(1));
                d0_next    = (XW+1)'(irdata) <<< 1;
                state_next = zpb_pkg::S_P_D2;
            end
            zpb_pkg::S_P_D2:
            begin
                d1_next    = (XW+1)'(irdata) <<< 1;
                n_next     = '0;
                state_next = zpb_pkg::S_P_RD;
            end
            zpb_pkg::S_P_RD:
            begin
                iraddr     = src_idx[IAW-1:0];
                state_next = zpb_pkg::S_P_WR;
            end
            zpb_pkg::S_P_WR:
            begin
                bwe    = 1'b1;
                n_next = n_reg + CW'(1);
                if (n_reg + CW'(1) == len_w)
                begin
                    pass_next  = 1'b0;
                    state_next = zpb_pkg::S_Z_RD;
                end
                else
                begin
                    state_next = zpb_pkg::S_P_RD;
                end
            end
            zpb_pkg::S_Z_RD:
            begin
                braddr     = pass_reg ? BAW'(len_w - CW'(1)) : '0;
                state_next = zpb_pkg::S_Z_X;
            end
            zpb_pkg::S_Z_X:
            begin
                x_next     = brdata;
                mac_s      = brdata;
                mac_c      = zpb_pkg::coef_zi(rate_reg, '0);
                j_next     = '0;
                state_next = zpb_pkg::S_Z_M;
            end
            zpb_pkg::S_Z_M:
            begin
                for (int i = 0; i < NZ - 1; i++)
                    z_next[i] = z_reg[i+1];
                z_next[NZ-1] = zi_sat;
                if (j_reg == JW'(NZ - 1))
                begin
                    n_next     = '0;
                    state_next = zpb_pkg::S_F_RD;
                end
                else
                begin
                    j_next = j_reg + JW'(1);
                    mac_c  = zpb_pkg::coef_zi(rate_reg, j_reg + JW'(1));
                end
            end
            zpb_pkg::S_F_RD:
            begin
                state_next = zpb_pkg::S_F_X;
            end
            zpb_pkg::S_F_X:
            begin
                x_next     = brdata;
                mac_s      = brdata;
                mac_c      = zpb_pkg::coef_b(rate_reg, '0);
                state_next = zpb_pkg::S_F_Y;
            end
            zpb_pkg::S_F_Y:
            begin
                y_next = y_sat;
                // state line rotates so the next tap always sits at the front
                for (int i = 0; i < NZ - 1; i++)
                    z_next[i] = z_reg[i+1];
                z_next[NZ-1] = z_reg[0];
                j_next     = JW'(1);
                mac_c      = zpb_pkg::coef_b(rate_reg, JW'(1));
                state_next = zpb_pkg::S_F_B;
            end
            zpb_pkg::S_F_B:
            begin
                acc_next   = ((j_reg == JW'(NZ)) ? AW'(0) : z0_ext) + rnd_ext;
                mac_s      = y_reg;
                mac_c      = zpb_pkg::coef_a(rate_reg, j_reg);
                state_next = zpb_pkg::S_F_A;
            end
            zpb_pkg::S_F_A:
            begin
                for (int i = 0; i < NZ - 1; i++)
                    z_next[i] = z_reg[i+1];
                z_next[NZ-1] = z_new;
                if (j_reg == JW'(NZ))
                begin
                    bwe    = 1'b1;
                    bwaddr = k_idx[BAW-1:0];
                    bwdata = y_reg;
                    if (pass_reg && k_inner && (y_mag > peak_reg))
                        peak_next = y_mag;
                    n_next = n_reg + CW'(1);
                    if (n_reg + CW'(1) == len_w)
                    begin
                        if (pass_reg)
                            state_next = zpb_pkg::S_CHECK;
                        else
                        begin
                            pass_next  = 1'b1;
                            state_next = zpb_pkg::S_Z_RD;
                        end
                    end
                    else
                    begin
                        state_next = zpb_pkg::S_F_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + JW'(1);
                    mac_c      = zpb_pkg::coef_b(rate_reg, j_reg + JW'(1));
                    state_next = zpb_pkg::S_F_B;
                end
            end
            zpb_pkg::S_CHECK:
            begin
                if (peak_reg == '0)
                begin
                    res_next   = '{filtered_value: '0, last_sample: 1'b1,
                                   status: zpb_pkg::STAT_ZERO};
                    state_next = zpb_pkg::S_EMIT;
                end
                else
                begin
                    ready_next = 1'b1;
                    ridx_next  = '0;
                    state_next = zpb_pkg::S_O_RD;
                end
            end
            zpb_pkg::S_O_RD:
            begin
                braddr     = BAW'(ridx_reg + CW'(PAD_LENGTH));
                state_next = zpb_pkg::S_O_Y;
            end
            zpb_pkg::S_O_Y:
            begin
                div_req.start = 1'b1;
                sign_next     = brdata[SW-1];
                state_next    = zpb_pkg::S_O_DIV;
            end
            zpb_pkg::S_O_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = '{filtered_value: q_val,
                                   last_sample: (ridx_reg + CW'(1) >= count_reg),
                                   status: zpb_pkg::STAT_OK};
                    state_next = zpb_pkg::S_EMIT;
                end
            end
            zpb_pkg::S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    if (res_reg.last_sample)
                    begin
                        count_next = '0;
                        ridx_next  = '0;
                        peak_next  = '0;
                        ready_next = 1'b0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        ridx_next = ridx_reg + CW'(1);
                    end
                    state_next = zpb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = zpb_pkg::S_IDLE;
            end
        endcase
    end

    a_ready_enough: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (count_reg >= CW'(PAD_LENGTH + 1)) && (peak_reg != '0))
        else $error("filtered block without enough samples or with zero peak");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CW'(MAX_SAMPLES)))
        else $error("overflow flagged on a block that is not full");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != zpb_pkg::STAT_OK)) |->
        (rsp.last_sample && (rsp.filtered_value == '0)))
        else $error("error word must be last and carry zero");

    a_ridx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (ridx_reg < count_reg))
        else $error("read index past end of block");

endmodule

### tb/tb_zero_phase_iir_bandpass_top.sv
// testbench for zero_phase_iir_bandpass_top: directed and random ecg blocks, each read
// checked against an in-bench forward-backward filter predictor; depends on zpb_pkg
`timescale 1ns / 1ps
module tb_zero_phase_iir_bandpass_top;

    localparam int NMAX  = 1024;
    localparam int PAD   = 18;
    localparam int BLEN  = NMAX + 2 * PAD;
    localparam longint SIGHI = 64'sd549755813887;
    localparam longint SIGLO = -64'sd549755813888;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    zpb_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_stall;
    zpb_pkg::rsp_t  rsp;
    logic           cfg_valid;
    logic           cfg_ready;
    logic           cfg_data;

    zero_phase_iir_bandpass_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    longint work_buf [0:BLEN-1];
    longint raw_buf [0:NMAX-1];
    int     n_loaded;
    int     rd_pos;
    longint peak_mag;
    bit     block_ready;
    bit     dropped;
    bit     rate;

    zpb_pkg::rsp_t expected_q [$];
    int     errors;
    int     burst_left;
    int     items_sent;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[zero_phase_iir_bandpass_top] ERROR");
        $finish;
    end

    function automatic longint sat40(longint v);
        if (v > SIGHI)
            return SIGHI;
        if (v < SIGLO)
            return SIGLO;
        return v;
    endfunction

    function automatic longint coef_mul(longint s, longint c);
        longint p;
        longint m;
        longint r;
        p = s * c;
        m = (p < 0) ? -p : p;
        r = (m + (64'sd1 <<< 19)) >>> 20;
        return (p < 0) ? -r : r;
    endfunction

    function automatic void filter_pass(bit rev, int len);
        longint z [0:zpb_pkg::TAPS-2];
        longint x;
        longint y;
        int     k;
        z[0] = 0;
        x = work_buf[rev ? len - 1 : 0];
        for (int j = 0; j < zpb_pkg::TAPS - 1; j++)
            z[j] = sat40(coef_mul(x, longint'(zpb_pkg::ZI_TAB[rate][j])));
        for (int n = 0; n < len; n++)
        begin
            k = rev ? len - 1 - n : n;
            x = work_buf[k];
            y = sat40(z[0] + coef_mul(x, longint'(zpb_pkg::B_TAB[rate][0])));
            for (int j = 1; j < zpb_pkg::TAPS - 1; j++)
                z[j-1] = sat40(z[j] + coef_mul(x, longint'(zpb_pkg::B_TAB[rate][j]))
                               - coef_mul(y, longint'(zpb_pkg::A_TAB[rate][j])));
            z[zpb_pkg::TAPS-2] =
                sat40(coef_mul(x, longint'(zpb_pkg::B_TAB[rate][zpb_pkg::TAPS-1]))
                      - coef_mul(y, longint'(zpb_pkg::A_TAB[rate][zpb_pkg::TAPS-1])));
            work_buf[k] = y;
        end
    endfunction

    function automatic void clear_block();
        n_loaded = 0;
        rd_pos = 0;
        peak_mag = 0;
        block_ready = 0;
        dropped = 0;
    endfunction

    function automatic void build_block();
        int     len;
        longint d0;
        longint d1;
        longint m;
        len = n_loaded + 2 * PAD;
        d0 = 2 * raw_buf[0];
        d1 = 2 * raw_buf[n_loaded-1];
        for (int i = 0; i < PAD; i++)
        begin
            work_buf[i] = (d0 - raw_buf[PAD-i]) * 256;
            work_buf[n_loaded+PAD+i] = (d1 - raw_buf[n_loaded-2-i]) * 256;
        end
        for (int i = 0; i < n_loaded; i++)
            work_buf[PAD+i] = raw_buf[i] * 256;
        filter_pass(1'b0, len);
        filter_pass(1'b1, len);
        peak_mag = 0;
        for (int i = 0; i < n_loaded; i++)
        begin
            m = work_buf[PAD+i];
            if (m < 0)
                m = -m;
            if (m > peak_mag)
                peak_mag = m;
        end
    endfunction

    // advance the predictor by one accepted word, queueing any result
    function automatic void predict_word(zpb_pkg::req_t w);
        zpb_pkg::rsp_t    r;
        zpb_pkg::status_t st;
        longint  y;
        longint  m;
        longint  q;
        if (w.kind == zpb_pkg::KIND_LOAD)
        begin
            if (block_ready)
                clear_block();
            if (n_loaded < NMAX)
            begin
                raw_buf[n_loaded] = longint'(w.sample_in);
                n_loaded++;
            end
            else
                dropped = 1;
            return;
        end
        if (!block_ready)
        begin
            st = zpb_pkg::STAT_OK;
            if (n_loaded < PAD + 1)
                st = zpb_pkg::STAT_FEW;
            else if (dropped)
                st = zpb_pkg::STAT_DROP;
            else
            begin
                build_block();
                if (peak_mag == 0)
                    st = zpb_pkg::STAT_ZERO;
            end
            if (st != zpb_pkg::STAT_OK)
            begin
                r.filtered_value = '0;
                r.last_sample = 1'b1;
                r.status = st;
                expected_q.push_back(r);
                clear_block();
                return;
            end
            block_ready = 1;
            rd_pos = 0;
        end
        y = work_buf[PAD+rd_pos];
        m = (y < 0) ? -y : y;
        q = ((m <<< 22) + peak_mag / 2) / peak_mag;
        r.filtered_value = (y < 0) ? zpb_pkg::VAL_W'(-q) : zpb_pkg::VAL_W'(q);
        r.last_sample = (rd_pos + 1 >= n_loaded);
        r.status = zpb_pkg::STAT_OK;
        expected_q.push_back(r);
        if (r.last_sample)
            clear_block();
        else
            rd_pos++;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker, sampled mid-cycle where everything is settled
    always @(negedge clk)
    begin
        zpb_pkg::rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected word, value", rsp.filtered_value, 0);
            else
            begin
                e = expected_q.pop_front();
                if (rsp.filtered_value !== e.filtered_value)
                    report_mismatch("filtered_value", rsp.filtered_value, e.filtered_value);
                if (rsp.last_sample !== e.last_sample)
                    report_mismatch("last_sample", rsp.last_sample, e.last_sample);
                if (rsp.status !== e.status)
                    report_mismatch("status", rsp.status, e.status);
            end
        end
    end

    // receiver stall pattern: modes of random length
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 400);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= ((stall_left % 16) < 5);
        endcase
    end

    task automatic send_word(logic kind, logic signed [zpb_pkg::SAMPLE_W-1:0] smp);
        zpb_pkg::req_t w;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        w.kind = kind;
        w.sample_in = smp;
        req <= w;
        req_valid <= 1'b1;
        do
            @(negedge clk);
        while (req_stall);
        @(posedge clk);
        predict_word(w);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        wait (expected_q.size() == 0);
        @(posedge clk);
    endtask

    task automatic set_rate(bit r);
        drain_results();
        repeat (60) @(posedge clk);
        cfg_data <= r;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        rate = r;
    endtask

    function automatic logic signed [zpb_pkg::SAMPLE_W-1:0] pick_sample(int style);
        case (style)
            0: return zpb_pkg::SAMPLE_W'($urandom);
            1: return zpb_pkg::SAMPLE_W'($signed($urandom_range(0, 4000)) - 2000);
            2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: return zpb_pkg::SAMPLE_W'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    task automatic load_block(int n, int style);
        for (int i = 0; i < n; i++)
            send_word(zpb_pkg::KIND_LOAD, pick_sample(style));
    endtask

    task automatic read_words(int k);
        for (int i = 0; i < k; i++)
            send_word(zpb_pkg::KIND_READ, pick_sample(0));
    endtask

    task automatic test_too_few();
        read_words(1);
        send_word(zpb_pkg::KIND_LOAD, 24'sh7fffff);
        read_words(1);
    endtask

    task automatic test_extremes();
        for (int i = 0; i < 19; i++)
            send_word(zpb_pkg::KIND_LOAD, (i % 2) ? 24'sh800000 : 24'sh7fffff);
        read_words(19);
    endtask

    task automatic test_zero_peak();
        for (int i = 0; i < 19; i++)
            send_word(zpb_pkg::KIND_LOAD, '0);
        read_words(2);
    endtask

    task automatic test_load_during_readout();
        load_block(20, 3);
        read_words(5);
        load_block(19, 0);
        read_words(19);
    endtask

    task automatic test_overflow();
        load_block(NMAX + 1, 1);
        read_words(1);
    endtask

    task automatic test_long_block();
        load_block(300, 1);
        read_words(40);
        load_block(19, 3);
        read_words(19);
    endtask

    task automatic test_random(int target);
        int n;
        int blocks;
        blocks = 0;
        while (items_sent < target)
        begin
            blocks++;
            if (blocks % 12 == 0)
                set_rate($urandom_range(0, 1));
            if (blocks % 17 == 0)
                drain_results();
            case ($urandom_range(0, 19))
                0: begin
                    // short block, read too early
                    load_block($urandom_range(0, PAD), $urandom_range(0, 3));
                    read_words($urandom_range(1, 2));
                end
                1: begin
                    load_block($urandom_range(19, 30), 1);
                    read_words($urandom_range(1, 6));
                end
                2: begin
                    load_block($urandom_range(19, 25), 0);
                    read_words($urandom_range(20, 30));
                end
                default: begin
                    n = $urandom_range(19, 48);
                    load_block(n, $urandom_range(0, 3));
                    read_words(n);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        errors = 0;
        burst_left = 0;
        items_sent = 0;
        rate = 1'b0;
        clear_block();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_rate(1'b0);
        test_too_few();
        test_extremes();
        test_zero_peak();
        set_rate(1'b1);
        test_extremes();
        test_load_during_readout();
        test_zero_peak();
        test_overflow();
        set_rate(1'b0);
        test_long_block();
        test_random(1950);

        req_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("[zero_phase_iir_bandpass_top] OK");
        else
            $display("[zero_phase_iir_bandpass_top] ERROR");
        $finish;
    end

endmodule
